/* rtl/core/oamu_pkg.sv */
`timescale 1ns / 1ps

package oamu_pkg;

    localparam int WORD_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int NREGS     = 8;
    localparam int RIDX_W    = $clog2(NREGS);
    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int UPC_W     = 4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [RIDX_W-1:0] ridx_t;
    typedef logic [UPC_W-1:0]  upc_t;
    typedef logic [1:0]        kind_t;
    typedef logic [5:0]        spec_t;

    localparam kind_t KIND_MEM     = 2'd0;
    localparam kind_t KIND_REG     = 2'd1;
    localparam kind_t KIND_RESOLVE = 2'd2;

    localparam ridx_t PC_IDX = ridx_t'(NREGS - 1);
    localparam word_t STEP   = word_t'(2);
    localparam ridx_t MODE_INDEX_DEF = ridx_t'(7);

    typedef enum logic [2:0] {
        A_HOLD,
        A_REG,
        A_REG_DEC,
        A_WORD,
        A_WORD_IDX
    } a_op_t;

    typedef enum logic [1:0] {
        RF_NONE,
        RF_INC,
        RF_DEC
    } rf_op_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_REG,
        EM_MEM
    } emit_t;

    typedef enum logic [1:0] {
        NX_SEQ,
        NX_JMP,
        NX_ODD,
        NX_END
    } nxt_t;

    typedef struct packed {
        a_op_t  a_op;
        logic   rsel_pc;
        rf_op_t rf_op;
        logic   mem_hi;
        logic   lat_lo;
        emit_t  emit;
        nxt_t   nxt;
        upc_t   target;
    } ctrl_t;

    // microprogram rows
    localparam upc_t ROW_IDX = upc_t'(6);
    localparam upc_t ROW_RD  = upc_t'(7);
    localparam upc_t ROW_IND = upc_t'(10);
    localparam upc_t ROW_OFF = upc_t'(13);

    localparam ctrl_t CTRL_IDLE = '{A_HOLD, 1'b0, RF_NONE, 1'b0, 1'b0, EM_NONE, NX_SEQ, '0};

    function automatic ctrl_t cw(a_op_t a, logic pc, rf_op_t r, logic hi, logic lat,
                                 emit_t em, nxt_t nx, upc_t tgt);
        ctrl_t c;
        c.a_op    = a;
        c.rsel_pc = pc;
        c.rf_op   = r;
        c.mem_hi  = hi;
        c.lat_lo  = lat;
        c.emit    = em;
        c.nxt     = nx;
        c.target  = tgt;
        return c;
    endfunction

    function automatic ctrl_t ucode_rom(upc_t upc);
        ctrl_t c;
        c = CTRL_IDLE;
        unique case (upc)
            4'd0:  c = cw(A_HOLD,     1'b0, RF_NONE, 1'b0, 1'b0, EM_REG,  NX_END, '0);
            4'd1:  c = cw(A_REG,      1'b0, RF_NONE, 1'b0, 1'b0, EM_NONE, NX_JMP, ROW_RD);
            4'd2:  c = cw(A_REG,      1'b0, RF_INC,  1'b0, 1'b0, EM_NONE, NX_JMP, ROW_RD);
            4'd3:  c = cw(A_REG,      1'b0, RF_INC,  1'b0, 1'b0, EM_NONE, NX_JMP, ROW_IND);
            4'd4:  c = cw(A_REG_DEC,  1'b0, RF_DEC,  1'b0, 1'b0, EM_NONE, NX_JMP, ROW_RD);
            4'd5:  c = cw(A_REG_DEC,  1'b0, RF_DEC,  1'b0, 1'b0, EM_NONE, NX_JMP, ROW_IND);
            4'd6:  c = cw(A_REG,      1'b1, RF_INC,  1'b0, 1'b0, EM_NONE, NX_JMP, ROW_OFF);
            4'd7:  c = cw(A_HOLD,     1'b0, RF_NONE, 1'b0, 1'b0, EM_NONE, NX_SEQ, '0);
            4'd8:  c = cw(A_HOLD,     1'b0, RF_NONE, 1'b1, 1'b1, EM_NONE, NX_SEQ, '0);
            4'd9:  c = cw(A_HOLD,     1'b0, RF_NONE, 1'b0, 1'b0, EM_MEM,  NX_END, '0);
            4'd10: c = cw(A_HOLD,     1'b0, RF_NONE, 1'b0, 1'b0, EM_NONE, NX_SEQ, '0);
            4'd11: c = cw(A_HOLD,     1'b0, RF_NONE, 1'b1, 1'b1, EM_NONE, NX_SEQ, '0);
            4'd12: c = cw(A_WORD,     1'b0, RF_NONE, 1'b0, 1'b0, EM_NONE, NX_JMP, ROW_RD);
            4'd13: c = cw(A_HOLD,     1'b0, RF_NONE, 1'b0, 1'b0, EM_NONE, NX_SEQ, '0);
            4'd14: c = cw(A_HOLD,     1'b0, RF_NONE, 1'b1, 1'b1, EM_NONE, NX_SEQ, '0);
            4'd15: c = cw(A_WORD_IDX, 1'b0, RF_NONE, 1'b0, 1'b0, EM_NONE, NX_ODD, ROW_IND);
        endcase
        return c;
    endfunction

    // entry row per addressing mode, both index modes share one
    function automatic upc_t entry_row(ridx_t mode);
        upc_t r;
        if (mode == MODE_INDEX_DEF)
        begin
            r = ROW_IDX;
        end
        else
        begin
            r = upc_t'(mode);
        end
        return r;
    endfunction

endpackage

/* rtl/core/oamu_ram.sv */
`timescale 1ns / 1ps

module oamu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/core/oamu_seq.sv */
`timescale 1ns / 1ps

module oamu_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  oamu_pkg::ridx_t mode,
    output logic            busy,
    output oamu_pkg::ctrl_t ctrl
);

    import oamu_pkg::*;

    logic  busy_reg, busy_next;
    upc_t  upc_reg, upc_next;
    ridx_t mode_reg, mode_next;
    ctrl_t rom_word;

    assign rom_word = ucode_rom(upc_reg);
    assign ctrl     = busy_reg ? rom_word : CTRL_IDLE;
    assign busy     = busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        mode_next = mode_reg;
        if (go)
        begin
            busy_next = 1'b1;
            upc_next  = entry_row(mode);
            mode_next = mode;
        end
        else if (busy_reg)
        begin
            unique case (rom_word.nxt)
                NX_SEQ: upc_next = upc_reg + upc_t'(1);
                NX_JMP: upc_next = rom_word.target;
                NX_ODD: upc_next = mode_reg[0] ? rom_word.target : ROW_RD;
                NX_END: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= '0;
            mode_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
            mode_reg <= mode_next;
        end
    end

endmodule

/* rtl/core/oamu_dp.sv */
`timescale 1ns / 1ps

module oamu_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  oamu_pkg::kind_t kind,
    input  oamu_pkg::word_t address,
    input  oamu_pkg::word_t data,
    input  oamu_pkg::ridx_t reg_index,
    input  oamu_pkg::ridx_t spec_reg,
    input  logic            go,
    input  logic            busy,
    input  oamu_pkg::ctrl_t ctrl,
    output logic            done,
    output oamu_pkg::word_t operand_address,
    output oamu_pkg::word_t operand_value,
    output logic            is_register
);

    import oamu_pkg::*;

    word_t rf_reg [NREGS];
    word_t a_reg, a_next;
    byte_t lo_reg;
    ridx_t n_reg;
    logic  done_reg, done_next;
    word_t oaddr_reg, oval_reg;
    logic  isreg_reg;

    ridx_t rsel;
    word_t rd;
    word_t wd;
    word_t rf_wdata;
    ridx_t rf_widx;
    logic  rf_we;
    word_t mem_word_addr;
    logic  mem_we;
    byte_t mem_rdata;

    assign rsel = ctrl.rsel_pc ? PC_IDX : n_reg;
    assign rd   = rf_reg[rsel];
    assign wd   = {mem_rdata, lo_reg};

    always_comb
    begin
        unique case (ctrl.a_op)
            A_REG:      a_next = rd;
            A_REG_DEC:  a_next = rd - STEP;
            A_WORD:     a_next = wd;
            A_WORD_IDX: a_next = wd + rd;
            default:    a_next = a_reg;
        endcase
    end

    always_comb
    begin
        rf_we    = 1'b0;
        rf_widx  = rsel;
        rf_wdata = data;
        if (accept && kind == KIND_REG)
        begin
            rf_we    = 1'b1;
            rf_widx  = reg_index;
            rf_wdata = data;
        end
        else
        begin
            unique case (ctrl.rf_op)
                RF_INC:
                begin
                    rf_we    = 1'b1;
                    rf_wdata = rd + STEP;
                end
                RF_DEC:
                begin
                    rf_we    = 1'b1;
                    rf_wdata = rd - STEP;
                end
                default:
                begin
                    rf_we = 1'b0;
                end
            endcase
        end
    end

    assign mem_we        = accept && kind == KIND_MEM;
    assign mem_word_addr = busy ? (ctrl.mem_hi ? a_reg + word_t'(1) : a_reg) : address;

    oamu_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MEM_BYTES)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_word_addr[MEM_AW-1:0]),
        .wdata(data[BYTE_W-1:0]),
        .rdata(mem_rdata)
    );

    assign done_next = ctrl.emit != EM_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                rf_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            if (rf_we)
            begin
                rf_reg[rf_widx] <= rf_wdata;
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        if (go)
        begin
            n_reg <= spec_reg;
        end
        if (ctrl.lat_lo)
        begin
            lo_reg <= mem_rdata;
        end
        if (ctrl.emit == EM_REG)
        begin
            oaddr_reg <= word_t'(n_reg);
            oval_reg  <= rd;
            isreg_reg <= 1'b1;
        end
        else if (ctrl.emit == EM_MEM)
        begin
            oaddr_reg <= a_reg;
            oval_reg  <= wd;
            isreg_reg <= 1'b0;
        end
    end

    assign done            = done_reg;
    assign operand_address = oaddr_reg;
    assign operand_value   = oval_reg;
    assign is_register     = isreg_reg;

endmodule

/* rtl/core/operand_addressing_mode_unit_core.sv */
// memory and register write transactions never raise busy
// a resolve transaction raises busy; done pulses for one cycle when the operand is ready;
// register mode reads no word, deferred/autoincrement/autodecrement read one word,
// their deferred forms two, index two, index deferred three, each as two bytes from the byte-wide memory port
// busy falls with done, so the next transaction may start in that cycle; the receiver cannot stall
// reset clears the eight registers to zero and the sequencer to idle; memory is not cleared
`timescale 1ns / 1ps

module operand_addressing_mode_unit_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  oamu_pkg::kind_t kind,
    input  oamu_pkg::word_t address,
    input  oamu_pkg::word_t data,
    input  oamu_pkg::ridx_t reg_index,
    input  oamu_pkg::spec_t specifier,
    output logic            done,
    output oamu_pkg::word_t operand_address,
    output oamu_pkg::word_t operand_value,
    output logic            is_register
);

    import oamu_pkg::*;

    logic  accept;
    logic  go;
    logic  seq_busy;
    ctrl_t ctrl;

    assign accept = start && !seq_busy;
    assign go     = accept && kind == KIND_RESOLVE;
    assign busy   = seq_busy;

    oamu_seq u_seq (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (go),
        .mode (specifier[5:3]),
        .busy (seq_busy),
        .ctrl (ctrl)
    );

    oamu_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .kind           (kind),
        .address        (address),
        .data           (data),
        .reg_index      (reg_index),
        .spec_reg       (specifier[2:0]),
        .go             (go),
        .busy           (seq_busy),
        .ctrl           (ctrl),
        .done           (done),
        .operand_address(operand_address),
        .operand_value  (operand_value),
        .is_register    (is_register)
    );

endmodule
